// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// File: rtl/tmq_pkg.sv
// ----------------------------------------------------------------------------
// tmq_pkg
// Types and constants of the timed message queue.
// ----------------------------------------------------------------------------
`default_nettype none

package tmq_pkg;

	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int TIME_BITS_DEF   = 48;

	localparam int TPM_W   = 10;
	localparam int RCV_W   = 16;
	localparam int MSG_W   = 32;
	localparam int EXTRA_W = 32;
	localparam int DELAY_W = 32;
	localparam int KEY_W   = 16;
	localparam int KIND_W  = 3;
	localparam int PROD_W  = DELAY_W + TPM_W;
	localparam int DATA_W  = 32;
	localparam int ADDR_W  = 2;

	localparam logic [TPM_W-1:0]  TPM_RESET = 10'd1;
	localparam logic [ADDR_W-1:0] ADDR_TPM  = 2'd0;
	localparam logic              MODE_POST = 1'b0;
	localparam logic              MODE_POLL = 1'b1;

	typedef enum logic [KIND_W-1:0] {
		KIND_OK      = 3'd0,
		KIND_FULL    = 3'd1,
		KIND_KEY     = 3'd2,
		KIND_IDLE    = 3'd3,
		KIND_RECV    = 3'd4,
		KIND_DEFAULT = 3'd5
	} kind_t;

	typedef struct packed {
		logic               has_rcv;
		logic [RCV_W-1:0]   rcv;
		logic [MSG_W-1:0]   msg;
		logic [EXTRA_W-1:0] extra;
	} msg_t;

endpackage

`default_nettype wire

// File: rtl/tmq_ram.sv
// ----------------------------------------------------------------------------
// tmq_ram
// Entry storage: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tmq_ram #(
	parameter int DEPTH     = tmq_pkg::QUEUE_DEPTH_DEF,
	parameter int TIME_BITS = tmq_pkg::TIME_BITS_DEF,
	localparam int IDX_W    = $clog2(DEPTH)
) (
	input  wire logic                 clk,
	input  wire logic                 we,
	input  wire logic [IDX_W-1:0]     waddr,
	input  wire logic [TIME_BITS-1:0] wdue,
	input  wire tmq_pkg::msg_t        wmsg,
	input  wire logic [IDX_W-1:0]     raddr,
	output logic [TIME_BITS-1:0]      rdue,
	output tmq_pkg::msg_t             rmsg
);
	import tmq_pkg::*;

	logic [TIME_BITS-1:0] due_mem [DEPTH];
	msg_t                 msg_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			due_mem[waddr] <= wdue;
			msg_mem[waddr] <= wmsg;
		end
		rdue <= due_mem[raddr];
		rmsg <= msg_mem[raddr];
	end

endmodule

`default_nettype wire

// File: rtl/timed_message_queue.sv
// ----------------------------------------------------------------------------
// timed_message_queue
// Bounded queue of delayed messages, sorted by due tick, with a poll tick.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its one result shows
// for a single cycle with done high and cannot be held off. Entries live in a
// circular RAM in due order. A poll with a key press or an empty queue answers
// in the next cycle without raising busy; a poll with entries holds busy in
// S_POP while the head is read and compared. A post holds busy through S_ADD,
// then S_SCAN and S_CMP in turn for each of the k entries due later than the
// new one (at most QUEUE_DEPTH - 1), each read and moved up one slot through
// the single RAM port pair and the one shared comparator; a last S_SCAN at
// the head, or an S_CMP at an entry due no later, writes the new entry
// in the freed slot. A post to a full queue answers at once.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module timed_message_queue #(
	parameter int QUEUE_DEPTH = tmq_pkg::QUEUE_DEPTH_DEF,
	parameter int TIME_BITS   = tmq_pkg::TIME_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [tmq_pkg::ADDR_W-1:0]    paddr,
	input  wire logic [tmq_pkg::DATA_W-1:0]    pwdata,
	output logic      [tmq_pkg::DATA_W-1:0]    prdata,
	output logic                               pready,
	input  wire logic                          start,
	output logic                               busy,
	output logic                               done,
	input  wire logic                          mode,
	input  wire logic                          receiver_present,
	input  wire logic [tmq_pkg::RCV_W-1:0]     receiver_id,
	input  wire logic signed [tmq_pkg::MSG_W-1:0] message_code,
	input  wire logic [tmq_pkg::EXTRA_W-1:0]   extra_word,
	input  wire logic [tmq_pkg::DELAY_W-1:0]   delay_ms,
	input  wire logic                          key_pressed,
	input  wire logic [tmq_pkg::KEY_W-1:0]     key_code,
	output logic      [tmq_pkg::KIND_W-1:0]    kind,
	output logic      [tmq_pkg::RCV_W-1:0]     out_receiver,
	output logic signed [tmq_pkg::MSG_W-1:0]   out_message,
	output logic      [tmq_pkg::EXTRA_W-1:0]   out_extra
);
	import tmq_pkg::*;

	localparam int IDX_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int SUM_W = ((TIME_BITS > PROD_W) ? TIME_BITS : PROD_W) + 1;
	localparam logic [TIME_BITS-1:0] TIME_MAX = '1;
	localparam logic [IDX_W-1:0]     LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0]     FULL_CNT = CNT_W'(QUEUE_DEPTH);
	localparam logic [IDX_W:0]       DEPTH_X  = (IDX_W + 1)'(QUEUE_DEPTH);

	typedef enum logic [2:0] {
		S_IDLE,
		S_POP,
		S_ADD,
		S_SCAN,
		S_CMP
	} state_t;

	function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] p);
		return (p == LAST_IDX) ? '0 : p + 1'b1;
	endfunction

	function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] p);
		return (p == '0) ? LAST_IDX : p - 1'b1;
	endfunction

	state_t               state_q;
	logic [TPM_W-1:0]     tpm_q;
	logic [TIME_BITS-1:0] now_q;
	logic [CNT_W-1:0]     count_q;
	logic [CNT_W-1:0]     left_q;
	logic [IDX_W-1:0]     head_q;
	logic [IDX_W-1:0]     idx_q;
	logic [PROD_W-1:0]    prod_q;
	logic [TIME_BITS-1:0] due_q;
	msg_t                 new_q;
	logic                 done_q;
	kind_t                kind_q;
	logic [RCV_W-1:0]     orcv_q;
	logic [MSG_W-1:0]     omsg_q;
	logic [EXTRA_W-1:0]   oext_q;

	logic                 ram_we;
	logic [IDX_W-1:0]     ram_waddr;
	logic [TIME_BITS-1:0] ram_wdue;
	msg_t                 ram_wmsg;
	logic [IDX_W-1:0]     ram_raddr;
	logic [TIME_BITS-1:0] rd_due;
	msg_t                 rd_msg;

	logic                 accept;
	logic                 cfg_wr;
	logic [IDX_W:0]       tail_sum;
	logic [IDX_W-1:0]     tail_idx;
	logic [TIME_BITS-1:0] cmp_b;
	logic                 rd_later;
	logic [SUM_W-1:0]     due_sum;
	logic [TIME_BITS-1:0] now_next;

	logic                 post_take;
	logic                 post_ok;
	logic                 pop_out;

	tmq_ram #(
		.DEPTH     (QUEUE_DEPTH),
		.TIME_BITS (TIME_BITS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdue  (ram_wdue),
		.wmsg  (ram_wmsg),
		.raddr (ram_raddr),
		.rdue  (rd_due),
		.rmsg  (rd_msg)
	);

	assign accept   = start && !busy;
	assign busy     = (state_q != S_IDLE);
	assign cfg_wr   = psel && penable && pwrite && pready && (paddr == ADDR_TPM);
	assign pready   = 1'b1;
	assign prdata   = (paddr == ADDR_TPM) ? DATA_W'(tpm_q) : '0;

	assign tail_sum = (IDX_W + 1)'(head_q) + (IDX_W + 1)'(count_q);
	assign tail_idx = (tail_sum >= DEPTH_X) ? IDX_W'(tail_sum - DEPTH_X) : tail_sum[IDX_W-1:0];
	assign now_next = (now_q == TIME_MAX) ? now_q : now_q + 1'b1;
	assign due_sum  = SUM_W'(now_q) + SUM_W'(prod_q);

	// shared comparator: head against now when popping, entry against new due when inserting
	assign cmp_b    = (state_q == S_POP) ? now_q : due_q;
	assign rd_later = (rd_due > cmp_b);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdue  = due_q;
		ram_wmsg  = new_q;
		ram_raddr = head_q;
		unique case (state_q)
			S_SCAN: begin
				if (left_q == '0) begin
					ram_we = 1'b1;
				end else begin
					ram_raddr = idx_dec(idx_q);
				end
			end
			S_CMP: begin
				ram_we = 1'b1;
				if (rd_later) begin
					ram_wdue = rd_due;
					ram_wmsg = rd_msg;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			tpm_q   <= TPM_RESET;
			now_q   <= '0;
			count_q <= '0;
			left_q  <= '0;
			head_q  <= '0;
			idx_q   <= '0;
			prod_q  <= '0;
			due_q   <= '0;
			new_q   <= '0;
			done_q  <= 1'b0;
			kind_q  <= KIND_OK;
			orcv_q  <= '0;
			omsg_q  <= '0;
			oext_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (cfg_wr) begin
				tpm_q <= pwdata[TPM_W-1:0];
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						orcv_q <= '0;
						omsg_q <= '0;
						oext_q <= '0;
						if (mode == MODE_POLL) begin
							now_q <= now_next;
							if (key_pressed) begin
								done_q <= 1'b1;
								kind_q <= KIND_KEY;
								oext_q <= EXTRA_W'(key_code);
							end else if (count_q == '0) begin
								done_q <= 1'b1;
								kind_q <= KIND_IDLE;
							end else begin
								state_q <= S_POP;
							end
						end else if (count_q == FULL_CNT) begin
							done_q <= 1'b1;
							kind_q <= KIND_FULL;
						end else begin
							prod_q  <= delay_ms * tpm_q;
							new_q   <= '{has_rcv: receiver_present, rcv: receiver_id,
								msg: message_code, extra: extra_word};
							idx_q   <= tail_idx;
							left_q  <= count_q;
							state_q <= S_ADD;
						end
					end
				end
				S_POP: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
					if (rd_later) begin
						kind_q <= KIND_IDLE;
					end else begin
						head_q  <= idx_inc(head_q);
						count_q <= count_q - 1'b1;
						kind_q  <= rd_msg.has_rcv ? KIND_RECV : KIND_DEFAULT;
						orcv_q  <= rd_msg.has_rcv ? rd_msg.rcv : '0;
						omsg_q  <= rd_msg.msg;
						oext_q  <= rd_msg.extra;
					end
				end
				S_ADD: begin
					due_q   <= (due_sum > SUM_W'(TIME_MAX)) ? TIME_MAX : due_sum[TIME_BITS-1:0];
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (left_q == '0) begin
						count_q <= count_q + 1'b1;
						done_q  <= 1'b1;
						kind_q  <= KIND_OK;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					if (rd_later) begin
						idx_q   <= idx_dec(idx_q);
						left_q  <= left_q - 1'b1;
						state_q <= S_SCAN;
					end else begin
						count_q <= count_q + 1'b1;
						done_q  <= 1'b1;
						kind_q  <= KIND_OK;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign done         = done_q;
	assign kind         = kind_q;
	assign out_receiver = orcv_q;
	assign out_message  = omsg_q;
	assign out_extra    = oext_q;

	assign post_take = accept && (mode == MODE_POST) && (count_q != FULL_CNT);
	assign post_ok   = done && (kind == KIND_OK);
	assign pop_out   = done && ((kind == KIND_RECV) || (kind == KIND_DEFAULT));

	`ASSERT_IMPLIES(a_count_bound, clk, arst_n, 1'b1, count_q <= FULL_CNT)
	`ASSERT_NEXT(a_post_busy, clk, arst_n, post_take, busy)
	`ASSERT_IMPLIES(a_post_grows, clk, arst_n, post_ok, count_q == $past(count_q) + 1'b1)
	`ASSERT_IMPLIES(a_pop_shrinks, clk, arst_n, pop_out, count_q == $past(count_q) - 1'b1)

endmodule

`default_nettype wire
